// ===== hw/rtl/pds_pkg.sv =====
// shared constants, codes and control structs of the positional deque store
// no dependencies; every other rtl file refers to it by scoped names
package pds_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);

   // fixed field widths of the channels
   localparam int CMD_W      = 3;
   localparam int POS_W      = 5;
   localparam int PAYLOAD_W  = 32;
   localparam int WORD_W     = 32;
   localparam int CNT_OUT_W  = 5;

   // common width for comparing position against fill
   localparam int CMP_W      = (POS_W > COUNT_W) ? POS_W : COUNT_W;

   typedef enum logic [CMD_W-1:0] {
      OP_APPEND       = 3'd0,
      OP_INS_FRONT    = 3'd1,
      OP_INS_AT       = 3'd2,
      OP_READ_AT      = 3'd3,
      OP_REMOVE_AT    = 3'd4,
      OP_REMOVE_FRONT = 3'd5,
      OP_REMOVE_BACK  = 3'd6,
      OP_COUNT        = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      FILL_HOLD = 2'd0,
      FILL_INC  = 2'd1,
      FILL_DEC  = 2'd2
   } fill_op_type;

   // controller to datapath
   typedef struct packed {
      logic              item_load;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_payload;
      logic              capture;
      fill_op_type       fill_op;
      logic              rsp_load;
      logic              rsp_ok;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] fill;
   } status_type;

endpackage

// ===== hw/rtl/pds_req_if.sv =====
// request channel of the positional deque store: valid, ready and one command beat
// depends on pds_pkg for the field widths
interface pds_req_if;
   logic                          valid;
   logic                          ready;
   logic [pds_pkg::CMD_W-1:0]     cmd;
   logic [pds_pkg::POS_W-1:0]     position;
   logic [pds_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, output cmd, output position, output payload, input ready);
   modport sink   (input valid, input cmd, input position, input payload, output ready);
endinterface

// ===== hw/rtl/pds_rsp_if.sv =====
// response channel of the positional deque store: valid, ready and one result beat
// depends on pds_pkg for the field widths
interface pds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [pds_pkg::WORD_W-1:0]    word_out;
   logic [pds_pkg::CNT_OUT_W-1:0] count;

   modport source (output valid, output ok, output word_out, output count, input ready);
   modport sink   (input valid, input ok, input word_out, input count, output ready);
endinterface

// ===== hw/rtl/positional_deque_store_core.sv =====
// top level of the positional deque store: request and response channels
// depends on pds_pkg, pds_req_if, pds_rsp_if, pds_controller and pds_datapath
//
// usage
//  - req_ch carries one command beat (cmd, position, payload); rsp_ch returns
//    exactly one beat per command (ok, word_out, count) in command order
//  - commands: append back, insert front, insert at position, read at
//    position, remove at position, remove front, remove back, report count
//  - a full store refuses adds, a bad position or an empty store gives ok low
//    with word_out zero and the store untouched
//  - one command at a time: req_ch.ready is high only while the block is idle
//  - count and refused commands go from decode straight to the response
//    state; a read, insert or remove first walks the single entry memory,
//    one entry a cycle
//  - the next command is taken the cycle after its predecessor's response is
//    loaded, even while that beat still waits on rsp_ch
//  - if rsp_ch stalls, a finished command waits in its last state until the
//    earlier beat is taken; nothing is lost or reordered
//  - reset (synchronous, active high) empties the store and drops any waiting
//    response beat; entry contents are left as they were, never read before
//    they are written
module positional_deque_store_core (
   input  logic      clock,
   input  logic      reset,
   pds_req_if.sink   req_ch,
   pds_rsp_if.source rsp_ch
);

   // command and status between the sequencer and the storage side
   pds_pkg::ctl_type    ctl;
   pds_pkg::status_type status;

   pds_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .ctl       (ctl)
   );

   // entries, fill count and the response registers live here
   pds_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .status       (status),
      .req_cmd      (req_ch.cmd),
      .req_position (req_ch.position),
      .req_payload  (req_ch.payload),
      .rsp_ok       (rsp_ch.ok),
      .rsp_word_out (rsp_ch.word_out),
      .rsp_count    (rsp_ch.count)
   );

endmodule

// ===== hw/rtl/pds_datapath.sv =====
// datapath: item registers, entry memory, fill counter and response registers
// depends on pds_pkg; driven by pds_controller through ctl_type
module pds_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pds_pkg::ctl_type              ctl,
   output pds_pkg::status_type           status,
   input  logic [pds_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pds_pkg::POS_W-1:0]     req_position,
   input  logic [pds_pkg::PAYLOAD_W-1:0] req_payload,
   output logic                          rsp_ok,
   output logic [pds_pkg::WORD_W-1:0]    rsp_word_out,
   output logic [pds_pkg::CNT_OUT_W-1:0] rsp_count
);

   pds_pkg::op_type                   op_ff;
   logic [pds_pkg::POS_W-1:0]         pos_ff;
   logic [pds_pkg::DATA_WIDTH-1:0]    data_ff;
   logic [pds_pkg::DATA_WIDTH-1:0]    mem [pds_pkg::DEPTH];
   logic [pds_pkg::DATA_WIDTH-1:0]    rd_data_ff;
   logic [pds_pkg::DATA_WIDTH-1:0]    word_ff;
   logic [pds_pkg::COUNT_W-1:0]       fill_ff;
   logic [pds_pkg::COUNT_W-1:0]       fill_in;
   logic                              rsp_ok_ff;
   logic [pds_pkg::DATA_WIDTH-1:0]    rsp_word_ff;
   logic [pds_pkg::CNT_OUT_W-1:0]     rsp_count_ff;
   logic [63:0]                       payload_wide;
   logic [63:0]                       word_wide;

   assign payload_wide = 64'(req_payload);
   assign word_wide    = 64'(rsp_word_ff);

   always_comb begin
      unique case (ctl.fill_op)
         pds_pkg::FILL_INC: fill_in = fill_ff + pds_pkg::COUNT_W'(1);
         pds_pkg::FILL_DEC: fill_in = fill_ff - pds_pkg::COUNT_W'(1);
         default:           fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // item capture and result word
   always_ff @(posedge clock) begin
      if (ctl.item_load) begin
         op_ff   <= pds_pkg::op_type'(req_cmd);
         pos_ff  <= req_position;
         data_ff <= payload_wide[pds_pkg::DATA_WIDTH-1:0];
         word_ff <= '0;
      end else if (ctl.capture) begin
         word_ff <= rd_data_ff;
      end
   end

   // entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_payload ? data_ff : rd_data_ff;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_ok_ff    <= ctl.rsp_ok;
         rsp_word_ff  <= word_ff;
         rsp_count_ff <= pds_pkg::CNT_OUT_W'(fill_in);
      end
   end

   assign status.op       = op_ff;
   assign status.position = pos_ff;
   assign status.fill     = fill_ff;

   assign rsp_ok       = rsp_ok_ff;
   assign rsp_word_out = word_wide[pds_pkg::WORD_W-1:0];
   assign rsp_count    = rsp_count_ff;

endmodule

// ===== hw/rtl/pds_controller.sv =====
// controller: decodes a command, walks the entry memory to read an entry or to open or close a gap
// depends on pds_pkg; drives pds_datapath through ctl_type
module pds_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  pds_pkg::status_type status,
   output pds_pkg::ctl_type    ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP,
      ST_DOWN,
      ST_FINISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [pds_pkg::COUNT_W-1:0]   ctr_ff, ctr_in;
   logic [pds_pkg::COUNT_W-1:0]   lim_ff, lim_in;
   logic [pds_pkg::ADDR_W-1:0]    base_ff, base_in;
   logic                          pend_ff, pend_in;
   logic [pds_pkg::ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                          ok_ff, ok_in;
   pds_pkg::fill_op_type          fop_ff, fop_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [pds_pkg::CMP_W-1:0]     pos_c;
   logic [pds_pkg::CMP_W-1:0]     fill_c;
   logic [pds_pkg::CMP_W-1:0]     ins_c;
   logic                          more;

   assign pos_c  = pds_pkg::CMP_W'(status.position);
   assign fill_c = pds_pkg::CMP_W'(status.fill);

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      lim_in       = lim_ff;
      base_in      = base_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      ok_in        = ok_ff;
      fop_in       = fop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.fill_op  = pds_pkg::FILL_HOLD;
      ins_c        = pos_c;
      more         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.item_load = 1'b1;
               state_in      = ST_DECODE;
            end
         end

         ST_DECODE: begin
            ok_in    = 1'b0;
            fop_in   = pds_pkg::FILL_HOLD;
            state_in = ST_FINISH;
            unique case (status.op)
               pds_pkg::OP_APPEND, pds_pkg::OP_INS_FRONT, pds_pkg::OP_INS_AT: begin
                  if (status.op == pds_pkg::OP_APPEND) begin
                     ins_c = fill_c;
                  end else if (status.op == pds_pkg::OP_INS_FRONT) begin
                     ins_c = '0;
                  end
                  if (fill_c < pds_pkg::CMP_W'(pds_pkg::DEPTH) && ins_c <= fill_c) begin
                     ok_in    = 1'b1;
                     fop_in   = pds_pkg::FILL_INC;
                     ctr_in   = status.fill;
                     base_in  = pds_pkg::ADDR_W'(ins_c);
                     state_in = ST_UP;
                  end
               end
               pds_pkg::OP_READ_AT: begin
                  if (pos_c < fill_c) begin
                     ok_in    = 1'b1;
                     ctr_in   = pds_pkg::COUNT_W'(status.position);
                     lim_in   = pds_pkg::COUNT_W'(status.position) + pds_pkg::COUNT_W'(1);
                     base_in  = pds_pkg::ADDR_W'(status.position);
                     state_in = ST_DOWN;
                  end
               end
               pds_pkg::OP_REMOVE_AT: begin
                  if (pos_c < fill_c) begin
                     ok_in    = 1'b1;
                     fop_in   = pds_pkg::FILL_DEC;
                     ctr_in   = pds_pkg::COUNT_W'(status.position);
                     lim_in   = status.fill;
                     base_in  = pds_pkg::ADDR_W'(status.position);
                     state_in = ST_DOWN;
                  end
               end
               pds_pkg::OP_REMOVE_FRONT: begin
                  if (status.fill != '0) begin
                     ok_in    = 1'b1;
                     fop_in   = pds_pkg::FILL_DEC;
                     ctr_in   = '0;
                     lim_in   = status.fill;
                     base_in  = '0;
                     state_in = ST_DOWN;
                  end
               end
               pds_pkg::OP_REMOVE_BACK: begin
                  if (status.fill != '0) begin
                     ok_in    = 1'b1;
                     fop_in   = pds_pkg::FILL_DEC;
                     ctr_in   = status.fill - pds_pkg::COUNT_W'(1);
                     lim_in   = status.fill;
                     base_in  = pds_pkg::ADDR_W'(status.fill - pds_pkg::COUNT_W'(1));
                     state_in = ST_DOWN;
                  end
               end
               pds_pkg::OP_COUNT: begin
                  ok_in = 1'b1;
               end
            endcase
         end

         // open a gap: read downwards from the back, write each word one higher
         ST_UP: begin
            more         = ctr_ff > pds_pkg::COUNT_W'(base_ff);
            ctl.rd_en    = more;
            ctl.rd_addr  = pds_pkg::ADDR_W'(ctr_ff - pds_pkg::COUNT_W'(1));
            pend_in      = more;
            pend_addr_in = ctl.rd_addr;
            if (more) begin
               ctr_in = ctr_ff - pds_pkg::COUNT_W'(1);
            end
            if (pend_ff) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_addr = pend_addr_ff + pds_pkg::ADDR_W'(1);
            end else if (!more) begin
               ctl.wr_en      = 1'b1;
               ctl.wr_addr    = base_ff;
               ctl.wr_payload = 1'b1;
               state_in       = ST_FINISH;
            end
         end

         // read from base upwards; first word is the result, the rest move one lower
         ST_DOWN: begin
            more         = ctr_ff < lim_ff;
            ctl.rd_en    = more;
            ctl.rd_addr  = ctr_ff[pds_pkg::ADDR_W-1:0];
            pend_in      = more;
            pend_addr_in = ctl.rd_addr;
            if (more) begin
               ctr_in = ctr_ff + pds_pkg::COUNT_W'(1);
            end
            if (pend_ff) begin
               if (pend_addr_ff == base_ff) begin
                  ctl.capture = 1'b1;
               end else begin
                  ctl.wr_en   = 1'b1;
                  ctl.wr_addr = pend_addr_ff - pds_pkg::ADDR_W'(1);
               end
            end else if (!more) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_ok   = ok_ff;
               ctl.fill_op  = fop_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         lim_ff       <= lim_in;
         base_ff      <= base_in;
         pend_ff      <= pend_in;
         pend_addr_ff <= pend_addr_in;
         ok_ff        <= ok_in;
         fop_ff       <= fop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_UP || state_ff == ST_DOWN))
      else $error("pending read outside a gap walk");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_en && ctl.rd_en) |-> (ctl.wr_addr != ctl.rd_addr))
      else $error("read and write hit the same entry");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !ctl.rsp_load)
      else $error("waiting response beat overwritten");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      status.fill <= pds_pkg::COUNT_W'(pds_pkg::DEPTH))
      else $error("fill beyond depth");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE && !rsp_valid_ff) ||
                                   (state_ff == ST_DECODE))
      else $error("accepted beat not decoded");

endmodule

// ===== verif/positional_deque_store_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for positional_deque_store_core: directed and random command beats
// depends on pds_pkg, pds_req_if, pds_rsp_if and the core itself
module positional_deque_store_core_tb;

   // one response beat as the bench expects to see it
   typedef struct packed {
      logic                          ok;
      logic [pds_pkg::WORD_W-1:0]    word_out;
      logic [pds_pkg::CNT_OUT_W-1:0] count;
   } rsp_beat_type;

   // how the random part leans: towards filling, towards draining, or neither
   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_EVEN
   } mix_type;

   logic clock = 1'b0;
   logic reset;

   pds_req_if req_ch ();
   pds_rsp_if rsp_ch ();

   positional_deque_store_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // shadow copy of the stored words, front at index 0
   logic [pds_pkg::PAYLOAD_W-1:0] mirror_words[$];
   // response beats owed by the core, oldest first
   rsp_beat_type                  owed_rsps[$];

   int error_total     = 0;
   bit idle_on         = 1'b1;
   int rsp_hold_cycles = 0;

   // apply one command to the shadow store and work out the beat it must return
   function automatic rsp_beat_type deque_apply(input pds_pkg::op_type op,
                                                input logic [pds_pkg::POS_W-1:0] pos,
                                                input logic [pds_pkg::PAYLOAD_W-1:0] data);
      rsp_beat_type beat;
      int           fill;
      int           at;
      beat = '0;
      fill = mirror_words.size();
      case (op)
         pds_pkg::OP_APPEND, pds_pkg::OP_INS_FRONT, pds_pkg::OP_INS_AT: begin
            // append lands at the back, insert front at position zero
            if (op == pds_pkg::OP_APPEND)
               at = fill;
            else if (op == pds_pkg::OP_INS_FRONT)
               at = 0;
            else
               at = int'(pos);
            // a full store refuses every add; position fill is a legal append
            if (fill < pds_pkg::DEPTH && at <= fill) begin
               mirror_words.insert(at, data);
               beat.ok = 1'b1;
            end
         end
         pds_pkg::OP_READ_AT: begin
            if (int'(pos) < fill) begin
               beat.word_out = mirror_words[pos];
               beat.ok       = 1'b1;
            end
         end
         pds_pkg::OP_REMOVE_AT: begin
            if (int'(pos) < fill) begin
               beat.word_out = mirror_words[pos];
               mirror_words.delete(pos);
               beat.ok       = 1'b1;
            end
         end
         pds_pkg::OP_REMOVE_FRONT: begin
            if (fill > 0) begin
               beat.word_out = mirror_words.pop_front();
               beat.ok       = 1'b1;
            end
         end
         pds_pkg::OP_REMOVE_BACK: begin
            if (fill > 0) begin
               beat.word_out = mirror_words.pop_back();
               beat.ok       = 1'b1;
            end
         end
         default: begin
            // count never fails
            beat.ok = 1'b1;
         end
      endcase
      beat.count = pds_pkg::CNT_OUT_W'(mirror_words.size());
      return beat;
   endfunction

   // offer one command beat after a random gap, hold it until taken, then predict it
   // valid is only lowered when a gap follows, so back-to-back beats keep it high
   task automatic issue_cmd(input pds_pkg::op_type op,
                            input logic [pds_pkg::POS_W-1:0] pos,
                            input logic [pds_pkg::PAYLOAD_W-1:0] data);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 17)) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= op;
      req_ch.position <= pos;
      req_ch.payload  <= data;
      do @(posedge clock); while (!req_ch.ready);
      owed_rsps.push_back(deque_apply(op, pos, data));
   endtask

   // mostly random words, with the all-zero and all-one extremes now and then
   function automatic logic [pds_pkg::PAYLOAD_W-1:0] pick_payload();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0)
         return '0;
      else if (roll == 1)
         return '1;
      return $urandom;
   endfunction

   // one random command, weighted by the mix; positions are mostly in range
   task automatic issue_random_cmd(input mix_type mix);
      int                          roll;
      int                          add_pct;
      int                          fill;
      pds_pkg::op_type             op;
      logic [pds_pkg::POS_W-1:0]   pos;
      fill = mirror_words.size();
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:   add_pct = 70;
         MIX_SHRINK: add_pct = 15;
         default:    add_pct = 40;
      endcase
      if (roll < add_pct)
         op = pds_pkg::op_type'($urandom_range(pds_pkg::OP_APPEND, pds_pkg::OP_INS_AT));
      else if (roll < 93)
         op = pds_pkg::op_type'($urandom_range(pds_pkg::OP_READ_AT,
                                               pds_pkg::OP_REMOVE_BACK));
      else
         op = pds_pkg::OP_COUNT;
      // stray positions cover the upper bits and every bad index
      if ($urandom_range(0, 9) < 8)
         pos = pds_pkg::POS_W'($urandom_range(0, fill));
      else
         pos = pds_pkg::POS_W'($urandom_range(0, (1 << pds_pkg::POS_W) - 1));
      issue_cmd(op, pos, pick_payload());
   endtask

   // response sink: random stall before each beat, or one long hold when asked
   initial begin : rsp_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = idle_on ? int'($urandom_range(0, 17)) : 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // compare every accepted response beat with the oldest owed one
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_rsps.size() == 0) begin
            $error("response beat with none owed: ok %0d word_out %h count %0d",
                   rsp_ch.ok, rsp_ch.word_out, rsp_ch.count);
            error_total++;
         end else begin
            want = owed_rsps.pop_front();
            if (rsp_ch.ok !== want.ok) begin
               $error("ok mismatch: expected %0d, got %0d", want.ok, rsp_ch.ok);
               error_total++;
            end
            if (rsp_ch.word_out !== want.word_out) begin
               $error("word_out mismatch: expected %h, got %h",
                      want.word_out, rsp_ch.word_out);
               error_total++;
            end
            if (rsp_ch.count !== want.count) begin
               $error("count mismatch: expected %0d, got %0d", want.count, rsp_ch.count);
               error_total++;
            end
         end
      end
   end

   // empty store refusals, insert position limits, reads and removes in the middle
   task automatic test_positions();
      issue_cmd(pds_pkg::OP_COUNT, 5'd0, '0);
      issue_cmd(pds_pkg::OP_REMOVE_FRONT, 5'd0, '0);
      issue_cmd(pds_pkg::OP_REMOVE_BACK, 5'd0, '0);
      issue_cmd(pds_pkg::OP_READ_AT, 5'd0, '0);
      issue_cmd(pds_pkg::OP_REMOVE_AT, 5'd0, '0);
      // insert past the end of an empty store
      issue_cmd(pds_pkg::OP_INS_AT, 5'd1, 32'h0bad_0bad);
      issue_cmd(pds_pkg::OP_INS_AT, 5'd0, '1);
      issue_cmd(pds_pkg::OP_INS_FRONT, 5'd0, '0);
      issue_cmd(pds_pkg::OP_APPEND, 5'd0, 32'ha5a5_5a5a);
      // position equal to fill acts as an append
      issue_cmd(pds_pkg::OP_INS_AT, 5'd3, 32'h1234_5678);
      issue_cmd(pds_pkg::OP_INS_AT, 5'd2, 32'h8765_4321);
      issue_cmd(pds_pkg::OP_READ_AT, 5'd0, '0);
      issue_cmd(pds_pkg::OP_READ_AT, 5'd4, '0);
      issue_cmd(pds_pkg::OP_READ_AT, 5'd5, '0);
      issue_cmd(pds_pkg::OP_READ_AT, 5'd31, '0);
      issue_cmd(pds_pkg::OP_REMOVE_AT, 5'd2, '0);
      issue_cmd(pds_pkg::OP_REMOVE_AT, 5'd4, '0);
      issue_cmd(pds_pkg::OP_REMOVE_AT, 5'd16, '0);
   endtask

   // fill to the brim, check every add is refused, then take from each end
   task automatic test_full_store();
      while (mirror_words.size() < pds_pkg::DEPTH)
         issue_cmd(pds_pkg::OP_APPEND, 5'd0, pick_payload());
      issue_cmd(pds_pkg::OP_APPEND, 5'd0, 32'hdead_beef);
      issue_cmd(pds_pkg::OP_INS_FRONT, 5'd0, 32'hdead_beef);
      issue_cmd(pds_pkg::OP_INS_AT, 5'd0, 32'hdead_beef);
      issue_cmd(pds_pkg::OP_INS_AT, 5'd16, 32'hdead_beef);
      issue_cmd(pds_pkg::OP_COUNT, 5'd0, '0);
      issue_cmd(pds_pkg::OP_READ_AT, 5'd15, '0);
      issue_cmd(pds_pkg::OP_REMOVE_BACK, 5'd0, '0);
      issue_cmd(pds_pkg::OP_REMOVE_FRONT, 5'd0, '0);
      issue_cmd(pds_pkg::OP_REMOVE_AT, 5'd0, '0);
   endtask

   // the sink holds off for a long stretch while beats keep coming, so the core
   // has to stall its request side
   task automatic test_rsp_backpressure();
      rsp_hold_cycles = 300;
      repeat (12) issue_random_cmd(MIX_EVEN);
   endtask

   // random beats in short runs, each with its own mix and idling on or off
   task automatic test_random_mix();
      mix_type mix;
      repeat (38) begin
         mix     = mix_type'($urandom_range(MIX_GROW, MIX_EVEN));
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (50) issue_random_cmd(mix);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= pds_pkg::OP_COUNT;
      req_ch.position <= '0;
      req_ch.payload  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_positions();
      test_full_store();
      test_rsp_backpressure();
      test_random_mix();

      // wait for every owed beat, then a little longer for any stray one
      req_ch.valid <= 1'b0;
      while (owed_rsps.size() != 0) @(posedge clock);
      repeat (pds_pkg::DEPTH + 10) @(posedge clock);

      if (error_total == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
